### rtl/cmdi_pkg.sv
// shared types and constants for the csr missing diagonal inserter
package cmdi_pkg;

   localparam int ColumnBits = 31;
   localparam int ValueBits  = 64;
   localparam int PosBits    = 32;

   localparam int ReqDataBits = 96;
   localparam int RspDataBits = 160;

   localparam logic KindEntry  = 1'b0;
   localparam logic KindMarker = 1'b1;

   typedef struct packed {
      logic                  has_entry;
      logic                  inserted;
      logic [ColumnBits-1:0] out_column;
      logic [ValueBits-1:0]  out_value_bits;
      logic [PosBits-1:0]    position;
      logic                  row_done;
      logic [PosBits-1:0]    row_end_offset;
   } result_type;

   typedef struct packed {
      result_type first;
      result_type second;
      logic [1:0] count;
   } push_type;

endpackage

### rtl/cmdi_core.sv
// row tracking, diagonal decision and position counting for each request
module cmdi_core import cmdi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [ColumnBits-1:0] csr_data,
   input  logic                  accept,
   input  logic                  kind,
   input  logic [ColumnBits-1:0] column,
   input  logic [ValueBits-1:0]  value_bits,
   input  logic                  last_in_row,
   output push_type              push
);

   logic [ColumnBits-1:0] column_count_ff, column_count_in;
   logic [ColumnBits-1:0] current_row_ff, current_row_in;
   logic                  diag_handled_ff, diag_handled_in;
   logic [PosBits-1:0]    write_pos_ff, write_pos_in;

   logic               wants_diag;
   logic               diag_first;
   logic               handled_mid;
   logic               tail;
   logic               done;
   logic [PosBits-1:0] pos_entry;
   logic [PosBits-1:0] pos_next;
   logic [PosBits-1:0] pos_next2;
   result_type         r_before, r_entry, r_tail, r_marker;

   always_comb begin
      wants_diag  = current_row_ff < column_count_ff;
      diag_first  = wants_diag && !diag_handled_ff && (column > current_row_ff);
      handled_mid = diag_handled_ff || diag_first || (column == current_row_ff);
      tail        = last_in_row && wants_diag && !handled_mid;
      done        = last_in_row && !tail;
      pos_entry   = write_pos_ff + PosBits'(diag_first);
      pos_next    = pos_entry + PosBits'(1);
      pos_next2   = pos_entry + PosBits'(2);

      r_before = '{has_entry: 1'b1, inserted: 1'b1, out_column: current_row_ff,
                   out_value_bits: '0, position: write_pos_ff, row_done: 1'b0,
                   row_end_offset: '0};
      r_entry  = '{has_entry: 1'b1, inserted: 1'b0, out_column: column,
                   out_value_bits: value_bits, position: pos_entry, row_done: done,
                   row_end_offset: done ? pos_next : '0};
      r_tail   = '{has_entry: 1'b1, inserted: 1'b1, out_column: current_row_ff,
                   out_value_bits: '0, position: pos_next, row_done: 1'b1,
                   row_end_offset: pos_next2};
      if (wants_diag) begin
         r_marker = '{has_entry: 1'b1, inserted: 1'b1, out_column: current_row_ff,
                      out_value_bits: '0, position: write_pos_ff, row_done: 1'b1,
                      row_end_offset: write_pos_ff + PosBits'(1)};
      end else begin
         r_marker = '{has_entry: 1'b0, inserted: 1'b0, out_column: '0,
                      out_value_bits: '0, position: '0, row_done: 1'b1,
                      row_end_offset: write_pos_ff};
      end

      column_count_in = csr_valid ? csr_data : column_count_ff;
      current_row_in  = current_row_ff;
      diag_handled_in = diag_handled_ff;
      write_pos_in    = write_pos_ff;
      push.first      = r_marker;
      push.second     = r_tail;
      push.count      = 2'd0;

      case (kind)
         KindMarker: begin
            push.first  = r_marker;
            push.second = r_tail;
            if (accept) begin
               push.count      = 2'd1;
               current_row_in  = current_row_ff + ColumnBits'(1);
               diag_handled_in = 1'b0;
               write_pos_in    = write_pos_ff + PosBits'(wants_diag);
            end
         end
         default: begin
            push.first  = diag_first ? r_before : r_entry;
            push.second = diag_first ? r_entry : r_tail;
            if (accept) begin
               push.count   = 2'd1 + 2'(diag_first) + 2'(tail);
               write_pos_in = tail ? pos_next2 : pos_next;
               if (last_in_row) begin
                  current_row_in  = current_row_ff + ColumnBits'(1);
                  diag_handled_in = 1'b0;
               end else begin
                  diag_handled_in = handled_mid;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         current_row_ff  <= '0;
         diag_handled_ff <= 1'b0;
         write_pos_ff    <= '0;
      end else begin
         column_count_ff <= column_count_in;
         current_row_ff  <= current_row_in;
         diag_handled_ff <= diag_handled_in;
         write_pos_ff    <= write_pos_in;
      end
   end

endmodule

### rtl/cmdi_out_buffer.sv
// two-slot result register queue feeding the response channel
module cmdi_out_buffer import cmdi_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output result_type head
);

   result_type slot0_ff, slot0_in;
   result_type slot1_ff, slot1_in;
   logic [1:0] count_ff, count_in;
   logic       pop;
   logic [1:0] rem_cnt;
   result_type rem0;

   always_comb begin
      pop     = rsp_tvalid && rsp_tready;
      rem_cnt = count_ff - 2'(pop);
      rem0    = pop ? slot1_ff : slot0_ff;
      room    = rem_cnt == 2'd0;
      if (rem_cnt == 2'd0) begin
         slot0_in = push.first;
         slot1_in = push.second;
      end else if (rem_cnt == 2'd1) begin
         slot0_in = rem0;
         slot1_in = push.first;
      end else begin
         slot0_in = rem0;
         slot1_in = slot1_ff;
      end
      count_in = rem_cnt + push.count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_tvalid = count_ff != 2'd0;
   assign head       = slot0_ff;

endmodule

### rtl/csr_missing_diagonal_inserter.sv
// top level of the csr missing diagonal inserter
//
// channel   direction  handshake             contents
// req_      in         tvalid/tready         one matrix entry or empty row marker
// rsp_      out        tvalid/tready         one output entry or row report
// csr_      in         valid/ready           column_count write
//
// a request is decided in the cycle it is accepted and is registered into a two-slot result
// queue; one request per cycle when each gives one response and rsp_tready is high
// an entry request that inserts a diagonal gives two responses and holds off the next request
// until the queue drains; req_tready is high only when the queue drains empty that cycle
// synchronous reset clears row, position and column_count; csr_ready is always high
module csr_missing_diagonal_inserter import cmdi_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [ReqDataBits-1:0] req_tdata,   // column[30:0], value_bits[94:31], zero
   input  logic                   req_tuser,   // kind
   input  logic                   req_tlast,   // last_in_row
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RspDataBits-1:0] rsp_tdata,   // out_column, out_value_bits, position,
                                               // row_end_offset, zero
   output logic [1:0]             rsp_tuser,   // has_entry, inserted
   output logic                   rsp_tlast,   // row_done
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [ColumnBits-1:0]  csr_data     // column_count
);

   push_type   push;
   result_type head;
   logic       room;
   logic       accept;

   assign req_tready = room;
   assign accept     = req_tvalid && room;
   assign csr_ready  = 1'b1;

   cmdi_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .accept      (accept),
      .kind        (req_tuser),
      .column      (req_tdata[ColumnBits-1:0]),
      .value_bits  (req_tdata[ColumnBits+ValueBits-1:ColumnBits]),
      .last_in_row (req_tlast),
      .push        (push)
   );

   cmdi_out_buffer u_out_buffer (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .head       (head)
   );

   assign rsp_tdata = {1'b0, head.row_end_offset, head.position, head.out_value_bits,
                       head.out_column};
   assign rsp_tuser = {head.inserted, head.has_entry};
   assign rsp_tlast = head.row_done;

endmodule

### test/tb.sv
// testbench for the csr missing diagonal inserter: directed table, random rows, predictor check
module tb;
   import cmdi_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [ColumnBits-1:0] MaxColumn = 31'h7FFF_FFFF;
   localparam logic [ValueBits-1:0]  AllOnes   = 64'hFFFF_FFFF_FFFF_FFFF;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ReqDataBits-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RspDataBits-1:0] rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [ColumnBits-1:0]  csr_data = '0;

   csr_missing_diagonal_inserter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // predictor state
   logic [ColumnBits-1:0] col_limit   = '0;
   logic [ColumnBits-1:0] row_idx     = '0;
   logic                  diag_placed = 1'b0;
   logic [PosBits-1:0]    out_pos     = '0;

   result_type pending_results [$];
   int         errors     = 0;
   int         items_sent = 0;
   int         hold_left  = 0;
   bit         quiet      = 1'b0;

   typedef struct {
      bit                    cfg;
      logic [ColumnBits-1:0] limit;
      logic                  kind;
      logic [ColumnBits-1:0] column;
      logic [ValueBits-1:0]  value;
      logic                  last;
      bit                    typed;
      result_type            want;
   } step_row_type;

   step_row_type directed [20] = '{
      '{0, 0, KindMarker, 0, 64'h0, 1, 1, '{0, 0, 0, 0, 0, 1, 0}},
      '{0, 0, KindEntry, 0, 64'h0, 1, 1, '{1, 0, 0, 0, 0, 1, 1}},
      '{0, 0, KindEntry, MaxColumn, AllOnes, 1, 1, '{1, 0, MaxColumn, AllOnes, 1, 1, 2}},
      '{1, 8, KindMarker, 0, 64'h0, 0, 1, '{1, 1, 3, 0, 2, 1, 3}},
      '{0, 0, KindEntry, 1, 64'h0123_4567_89AB_CDEF, 0, 0, '0},
      '{0, 0, KindEntry, 5, 64'hFEDC_BA98_7654_3210, 1, 0, '0},
      '{0, 0, KindEntry, 5, 64'h5555_5555_5555_5555, 0, 0, '0},
      '{0, 0, KindEntry, 5, 64'hAAAA_AAAA_AAAA_AAAA, 1, 0, '0},
      '{0, 0, KindEntry, 0, 64'h8000_0000_0000_0001, 0, 0, '0},
      '{0, 0, KindEntry, 2, 64'h0000_0001_0000_0000, 1, 0, '0},
      '{0, 0, KindEntry, 9, 64'h1111_2222_3333_4444, 0, 0, '0},
      '{0, 0, KindEntry, 7, 64'h5555_6666_7777_8888, 0, 0, '0},
      '{0, 0, KindEntry, 3, 64'h9999_AAAA_BBBB_CCCC, 1, 0, '0},
      '{0, 0, KindMarker, 0, 64'h0, 1, 0, '0},
      '{1, MaxColumn, KindEntry, MaxColumn, AllOnes, 1, 0, '0},
      '{0, 0, KindEntry, 10, 64'hDEAD_BEEF_CAFE_F00D, 1, 0, '0},
      '{1, 0, KindEntry, 11, 64'h0F0F_0F0F_0F0F_0F0F, 1, 0, '0},
      '{0, 0, KindMarker, MaxColumn, AllOnes, 0, 0, '0},
      '{1, 14, KindEntry, 12, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, '0},
      '{0, 0, KindEntry, 20, 64'h0000_0000_0000_0002, 1, 0, '0}
   };

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #4ms;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic result_type make_result(input logic has, input logic ins,
                                              input logic [ColumnBits-1:0] col,
                                              input logic [ValueBits-1:0] val,
                                              input logic [PosBits-1:0] pos,
                                              input logic done,
                                              input logic [PosBits-1:0] offset);
      result_type r;
      r.has_entry      = has;
      r.inserted       = ins;
      r.out_column     = col;
      r.out_value_bits = val;
      r.position       = pos;
      r.row_done       = done;
      r.row_end_offset = offset;
      return r;
   endfunction

   task automatic predict_request(input logic kind, input logic [ColumnBits-1:0] col,
                                  input logic [ValueBits-1:0] val, input logic last);
      logic wants;
      logic tail;
      logic done;
      wants = row_idx < col_limit;
      if (kind == KindMarker) begin
         if (wants) begin
            out_pos = out_pos + 1;
            pending_results.push_back(make_result(1, 1, row_idx, '0, out_pos - 1, 1, out_pos));
         end else begin
            pending_results.push_back(make_result(0, 0, '0, '0, '0, 1, out_pos));
         end
         row_idx = row_idx + ColumnBits'(1);
         diag_placed = 1'b0;
         return;
      end
      // diagonal goes in front of the first column past the row
      if (wants && !diag_placed && col > row_idx) begin
         pending_results.push_back(make_result(1, 1, row_idx, '0, out_pos, 0, '0));
         out_pos = out_pos + 1;
         diag_placed = 1'b1;
      end
      if (col == row_idx)
         diag_placed = 1'b1;
      tail = last && wants && !diag_placed;
      done = last && !tail;
      out_pos = out_pos + 1;
      pending_results.push_back(make_result(1, 0, col, val, out_pos - 1, done,
                                            done ? out_pos : '0));
      if (tail) begin
         out_pos = out_pos + 1;
         pending_results.push_back(make_result(1, 1, row_idx, '0, out_pos - 1, 1, out_pos));
      end
      if (last) begin
         row_idx = row_idx + ColumnBits'(1);
         diag_placed = 1'b0;
      end
   endtask

   task automatic send_request(input logic kind, input logic [ColumnBits-1:0] col,
                               input logic [ValueBits-1:0] val, input logic last);
      while (!quiet && $urandom_range(0, 99) < 10) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, val, col};
      req_tuser  <= kind;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      predict_request(kind, col, val, last);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_limit(input logic [ColumnBits-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      col_limit = value;
   endtask

   task automatic send_row(input bit noisy);
      int              n;
      int              i;
      logic [31:0]     c;
      logic [63:0]     val;
      if ($urandom_range(0, 99) < 12) begin
         val = {$urandom, $urandom};
         send_request(KindMarker, ColumnBits'($urandom), val, 1'($urandom_range(0, 1)));
         return;
      end
      n = $urandom_range(1, 6);
      // unsorted columns, stray bits, rows that may not close where planned
      if (noisy) begin
         for (i = 0; i < n; i++) begin
            val = {$urandom, $urandom};
            c = $urandom_range(0, 1) ? $urandom : row_idx + $urandom_range(0, 4) - 2;
            send_request(KindEntry, c[ColumnBits-1:0], val, $urandom_range(0, 3) == 0);
         end
         return;
      end
      c = (row_idx > 3) ? row_idx - $urandom_range(0, 3) : '0;
      for (i = 0; i < n; i++) begin
         val = {$urandom, $urandom};
         send_request(KindEntry, c[ColumnBits-1:0], val, i == n - 1);
         c = c + $urandom_range(0, 2);
      end
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
   endtask

   task automatic check_response();
      result_type got;
      result_type want;
      got.has_entry      = rsp_tuser[0];
      got.inserted       = rsp_tuser[1];
      got.out_column     = rsp_tdata[30:0];
      got.out_value_bits = rsp_tdata[94:31];
      got.position       = rsp_tdata[126:95];
      got.row_end_offset = rsp_tdata[158:127];
      got.row_done       = rsp_tlast;
      if (pending_results.size() == 0) begin
         errors++;
         $display("%0t: unexpected response expected none got %h", $time, got);
         return;
      end
      want = pending_results.pop_front();
      compare_field("has_entry", want.has_entry, got.has_entry);
      compare_field("inserted", want.inserted, got.inserted);
      compare_field("out_column", want.out_column, got.out_column);
      compare_field("out_value_bits", want.out_value_bits, got.out_value_bits);
      compare_field("position", want.position, got.position);
      compare_field("row_done", want.row_done, got.row_done);
      compare_field("row_end_offset", want.row_end_offset, got.row_end_offset);
   endtask

   // response side
   initial begin
      while (reset)
         @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            check_response();
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet || $urandom_range(0, 99) >= 10;
         end
      end
   end

   // request side
   initial begin
      int ph;
      int k;
      int phase_start;
      logic [ColumnBits-1:0] limit;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < $size(directed); k++) begin
         if (directed[k].cfg) begin
            drain_results();
            write_limit(directed[k].limit);
         end
         send_request(directed[k].kind, directed[k].column, directed[k].value,
                      directed[k].last);
         if (directed[k].typed) begin
            void'(pending_results.pop_back());
            pending_results.push_back(directed[k].want);
         end
      end

      for (ph = 0; ph < 8; ph++) begin
         drain_results();
         if (ph == 2)
            limit = MaxColumn;
         else if (ph == 6)
            limit = '0;
         else
            limit = ColumnBits'(row_idx + $urandom_range(0, 120));
         write_limit(limit);
         quiet = (ph == 3);
         // long receiver stall so the result queue fills and stalls requests
         if (ph == 5)
            hold_left = 300;
         phase_start = items_sent;
         while (items_sent - phase_start < 180)
            send_row($urandom_range(0, 9) == 0);
      end

      quiet = 1'b0;
      drain_results();
      repeat (10) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
